// ----- src/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the barycentric triangle pixel shader.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

    localparam int SCREEN_BITS      = 12;
    localparam int COORD_FRAC_BITS  = 4;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 8;
    localparam int DIM_W     = 13;
    localparam int POS_W     = SCREEN_BITS + COORD_FRAC_BITS + 1;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = POS_W + DIFF_W;
    localparam int CROSS_W   = 2 * COORD_W;
    localparam int EDGE_W    = PROD_W + 2;
    localparam int SAT_SHIFT = 9;
    localparam int WQ_W      = WEIGHT_FRAC_BITS + SAT_SHIFT;
    localparam int SUM_W     = WQ_W + COLOR_W + 2;
    localparam int QDEPTH    = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] SLOT_NONE = 2'd3;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic                      is_query;
        logic [1:0]                slot;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic [SCREEN_BITS-1:0]    qx;
        logic [SCREEN_BITS-1:0]    qy;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

`default_nettype wire

// ----- src/bts_front.sv -----
// ----------------------------------------------------------------------------
// bts_front
// Input side: accept items, drop void vertex loads, queue the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire bts_pkg::item_t       in_item,
    input  wire logic                 pop,
    output bts_pkg::queue_head_t      head
);
    import bts_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    item_t              mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push;

    assign in_stall   = (cnt_reg == CNT_W'(QDEPTH));
    assign push       = in_valid && !in_stall &&
                        (in_item.is_query || in_item.slot != SLOT_NONE);
    assign head.valid = (cnt_reg != '0);
    assign head.item  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/bts_back.sv -----
// ----------------------------------------------------------------------------
// bts_back
// Execution side: vertex store, edge functions, three bit-serial dividers,
// colour blend and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bts_pkg::queue_head_t          head,
    output logic                               pop,
    input  wire logic [bts_pkg::DIM_W-1:0]     screen_width,
    input  wire logic [bts_pkg::DIM_W-1:0]     screen_height,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bts_pkg::SCREEN_BITS-1:0]    pixel_col,
    output logic [bts_pkg::SCREEN_BITS-1:0]    pixel_row,
    output logic                               covered,
    output logic [bts_pkg::COLOR_W-1:0]        shade_red,
    output logic [bts_pkg::COLOR_W-1:0]        shade_green,
    output logic [bts_pkg::COLOR_W-1:0]        shade_blue
);
    import bts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_DEN, S_PREP, S_DIV, S_BLEND, S_OUT
    } state_t;

    localparam int CNT_W = $clog2(WQ_W);

    state_t                      state_reg;
    logic signed [COORD_W-1:0]   cx_reg [3];
    logic signed [COORD_W-1:0]   cy_reg [3];
    logic [COLOR_W-1:0]          cr_reg [3];
    logic [COLOR_W-1:0]          cg_reg [3];
    logic [COLOR_W-1:0]          cb_reg [3];
    logic [SCREEN_BITS-1:0]      qx_reg, qy_reg;
    logic signed [PROD_W-1:0]    ma_reg [3];
    logic signed [PROD_W-1:0]    mb_reg [3];
    logic signed [CROSS_W-1:0]   mc_reg [3];
    logic signed [CROSS_W-1:0]   md_reg [3];
    logic signed [EDGE_W-1:0]    e_reg [3];
    logic signed [EDGE_W-1:0]    den_reg;
    logic [EDGE_W-1:0]           ud_reg;
    logic [EDGE_W-1:0]           rem_reg [3];
    logic [WQ_W-1:0]             feed_reg [3];
    logic [WQ_W-1:0]             q_reg [3];
    logic                        big_reg [3];
    logic [CNT_W-1:0]            cnt_reg;
    logic                        cov_reg;
    logic [SUM_W-1:0]            sum_reg [3];
    logic                        out_valid_reg;
    logic [SCREEN_BITS-1:0]      col_reg, row_reg;
    logic                        covered_reg;
    logic [COLOR_W-1:0]          red_reg, green_reg, blue_reg;

    logic signed [POS_W-1:0]     px, py;
    logic signed [DIFF_W-1:0]    dy [3];
    logic signed [DIFF_W-1:0]    dx [3];
    logic [EDGE_W-1:0]           un [3];
    logic [EDGE_W-1:0]           ud;
    logic                        big [3];
    logic                        sign_ok;
    logic                        cov;
    logic [EDGE_W:0]             trial [3];
    logic                        fits [3];
    logic [EDGE_W-1:0]           rem_next [3];
    logic [WQ_W-1:0]             w [3];
    logic [COLOR_W-1:0]          shade [3];
    logic                        out_load;

    function automatic logic [1:0] edge_a(input int k);
        return (k == 0) ? 2'd1 : (k == 1) ? 2'd2 : 2'd0;
    endfunction

    function automatic logic [1:0] edge_b(input int k);
        return (k == 0) ? 2'd2 : (k == 1) ? 2'd0 : 2'd1;
    endfunction

    assign pop      = (state_reg == S_IDLE) && head.valid;
    assign px       = {1'b0, qx_reg, {COORD_FRAC_BITS{1'b0}}};
    assign py       = {1'b0, qy_reg, {COORD_FRAC_BITS{1'b0}}};
    assign ud       = den_reg[EDGE_W-1] ? EDGE_W'(-den_reg) : EDGE_W'(den_reg);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        sign_ok = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            dy[k]    = DIFF_W'(cy_reg[edge_a(k)]) - DIFF_W'(cy_reg[edge_b(k)]);
            dx[k]    = DIFF_W'(cx_reg[edge_b(k)]) - DIFF_W'(cx_reg[edge_a(k)]);
            un[k]    = e_reg[k][EDGE_W-1] ? EDGE_W'(-e_reg[k]) : EDGE_W'(e_reg[k]);
            big[k]   = {{SAT_SHIFT{1'b0}}, un[k]} >= {ud, {SAT_SHIFT{1'b0}}};
            trial[k] = {rem_reg[k], feed_reg[k][WQ_W-1]};
            fits[k]  = trial[k] >= {1'b0, ud_reg};
            rem_next[k] = fits[k] ? EDGE_W'(trial[k] - {1'b0, ud_reg})
                                  : EDGE_W'(trial[k]);
            w[k]     = big_reg[k] ? {WQ_W{1'b1}} : q_reg[k];
            shade[k] = (|sum_reg[k][SUM_W-1:WEIGHT_FRAC_BITS+COLOR_W])
                       ? {COLOR_W{1'b1}}
                       : sum_reg[k][WEIGHT_FRAC_BITS +: COLOR_W];
            if (e_reg[k] != '0 && e_reg[k][EDGE_W-1] != den_reg[EDGE_W-1])
            begin
                sign_ok = 1'b0;
            end
        end
        cov = (den_reg != '0) && sign_ok &&
              ({1'b0, qx_reg} < screen_width) && ({1'b0, qy_reg} < screen_height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                cx_reg[k] <= '0;
                cy_reg[k] <= '0;
                cr_reg[k] <= '0;
                cg_reg[k] <= '0;
                cb_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        if (head.item.is_query == OP_QUERY)
                        begin
                            qx_reg    <= head.item.qx;
                            qy_reg    <= head.item.qy;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            cx_reg[head.item.slot] <= head.item.vx;
                            cy_reg[head.item.slot] <= head.item.vy;
                            cr_reg[head.item.slot] <= head.item.red;
                            cg_reg[head.item.slot] <= head.item.green;
                            cb_reg[head.item.slot] <= head.item.blue;
                        end
                    end
                end
                S_MUL:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        ma_reg[k] <= px * dy[k];
                        mb_reg[k] <= py * dx[k];
                        mc_reg[k] <= cx_reg[edge_a(k)] * cy_reg[edge_b(k)];
                        md_reg[k] <= cy_reg[edge_a(k)] * cx_reg[edge_b(k)];
                    end
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        e_reg[k] <= EDGE_W'(ma_reg[k]) + EDGE_W'(mb_reg[k])
                                  + EDGE_W'(mc_reg[k]) - EDGE_W'(md_reg[k]);
                    end
                    state_reg <= S_DEN;
                end
                S_DEN:
                begin
                    den_reg   <= e_reg[0] + e_reg[1] + e_reg[2];
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    cov_reg <= cov;
                    ud_reg  <= ud;
                    cnt_reg <= '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        big_reg[k]  <= big[k];
                        rem_reg[k]  <= un[k] >> SAT_SHIFT;
                        feed_reg[k] <= {un[k][SAT_SHIFT-1:0],
                                        {WEIGHT_FRAC_BITS{1'b0}}};
                        q_reg[k]    <= '0;
                    end
                    state_reg <= cov ? S_DIV : S_OUT;
                end
                S_DIV:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        rem_reg[k]  <= rem_next[k];
                        feed_reg[k] <= feed_reg[k] << 1;
                        q_reg[k]    <= {q_reg[k][WQ_W-2:0], fits[k]};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WQ_W - 1))
                    begin
                        state_reg <= S_BLEND;
                    end
                end
                S_BLEND:
                begin
                    sum_reg[0] <= SUM_W'(w[0] * cr_reg[0]) + SUM_W'(w[1] * cr_reg[1])
                                + SUM_W'(w[2] * cr_reg[2]);
                    sum_reg[1] <= SUM_W'(w[0] * cg_reg[0]) + SUM_W'(w[1] * cg_reg[1])
                                + SUM_W'(w[2] * cg_reg[2]);
                    sum_reg[2] <= SUM_W'(w[0] * cb_reg[0]) + SUM_W'(w[1] * cb_reg[1])
                                + SUM_W'(w[2] * cb_reg[2]);
                    state_reg  <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        col_reg       <= qx_reg;
                        row_reg       <= qy_reg;
                        covered_reg   <= cov_reg;
                        red_reg       <= cov_reg ? shade[0] : '0;
                        green_reg     <= cov_reg ? shade[1] : '0;
                        blue_reg      <= cov_reg ? shade[2] : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_col   = col_reg;
    assign pixel_row   = row_reg;
    assign covered     = covered_reg;
    assign shade_red   = red_reg;
    assign shade_green = green_reg;
    assign shade_blue  = blue_reg;

endmodule

`default_nettype wire

// ----- src/barycentric_triangle_pixel_shader_top.sv -----
// ----------------------------------------------------------------------------
// barycentric_triangle_pixel_shader_top
// Pixel coverage and colour by barycentric weights of a stored triangle.
// ----------------------------------------------------------------------------
// A vertex load is stored by the execution side from its idle state; a pixel
// query there leaves the queue, passes the states for the edge functions, the
// shared denominator and the coverage test, then the three bit-serial
// weight dividers running side by side (one quotient bit per cycle each),
// the colour blend and the output register, which waits while out_stall
// holds it. Uncovered pixels skip the dividers and the blend. A two-entry
// input queue lets new items arrive while a query runs.
`default_nettype none

module barycentric_triangle_pixel_shader_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 operation,
    input  wire logic [1:0]           vertex_slot,
    input  wire logic signed [15:0]   vertex_x,
    input  wire logic signed [15:0]   vertex_y,
    input  wire logic [7:0]           vertex_red,
    input  wire logic [7:0]           vertex_green,
    input  wire logic [7:0]           vertex_blue,
    input  wire logic [11:0]          query_x,
    input  wire logic [11:0]          query_y,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [11:0]               pixel_col,
    output logic [11:0]               pixel_row,
    output logic                      covered,
    output logic [7:0]                shade_red,
    output logic [7:0]                shade_green,
    output logic [7:0]                shade_blue,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [12:0]          cfg_data
);
    import bts_pkg::*;

    item_t              in_item;
    queue_head_t        head;
    logic               pop;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    assign in_item.is_query = operation;
    assign in_item.slot     = vertex_slot;
    assign in_item.vx       = vertex_x;
    assign in_item.vy       = vertex_y;
    assign in_item.red      = vertex_red;
    assign in_item.green    = vertex_green;
    assign in_item.blue     = vertex_blue;
    assign in_item.qx       = query_x;
    assign in_item.qy       = query_y;

    bts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .pop      (pop),
        .head     (head)
    );

    bts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_col     (pixel_col),
        .pixel_row     (pixel_row),
        .covered       (covered),
        .shade_red     (shade_red),
        .shade_green   (shade_green),
        .shade_blue    (shade_blue)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    a_cover_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && covered) |->
            ({1'b0, pixel_col} < width_reg && {1'b0, pixel_row} < height_reg))
        else $error("covered pixel outside screen");

    a_dark_uncovered: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && !covered |->
            (shade_red == '0 && shade_green == '0 && shade_blue == '0))
        else $error("uncovered pixel carries colour");

endmodule

`default_nettype wire

// ----- dv/barycentric_triangle_pixel_shader_top_test.sv -----
// ----------------------------------------------------------------------------
// barycentric_triangle_pixel_shader_top_test
// Drives vertex loads, pixel queries and screen size writes into the shader,
// predicts coverage and blended colour of every query, and compares each
// pixel transfer field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module barycentric_triangle_pixel_shader_top_test;
    import bts_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [11:0] col;
        logic [11:0] row;
        logic        cov;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = OP_LOAD;
    logic [1:0] vertex_slot = 2'd0;
    logic signed [15:0] vertex_x = '0;
    logic signed [15:0] vertex_y = '0;
    logic [7:0] vertex_red = '0;
    logic [7:0] vertex_green = '0;
    logic [7:0] vertex_blue = '0;
    logic [11:0] query_x = '0;
    logic [11:0] query_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic covered;
    logic [7:0] shade_red;
    logic [7:0] shade_green;
    logic [7:0] shade_blue;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = REG_SCREEN_WIDTH;
    logic [12:0] cfg_data = '0;

    pixel_t expected_pixels[$];
    longint corner_px[3];
    longint corner_py[3];
    logic [23:0] corner_rgb[3];
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    bit quiet = 1'b0;
    int errors = 0;
    int cycles = 0;

    barycentric_triangle_pixel_shader_top DUT (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint edge_val(int a, int b, longint px, longint py);
        return px * (corner_py[a] - corner_py[b]) + py * (corner_px[b] - corner_px[a])
            + corner_px[a] * corner_py[b] - corner_py[a] * corner_px[b];
    endfunction

    function automatic bit weight_ok(longint num, longint den, output longint w);
        longint un;
        longint ud;
        w = 0;
        if (num == 0)
            return 1'b1;
        if ((num < 0) != (den < 0))
            return 1'b0;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        w = (un <<< WEIGHT_FRAC_BITS) / ud;
        return 1'b1;
    endfunction

    function automatic logic [7:0] blend(longint w[3], int shift);
        longint sum;
        sum = 0;
        for (int k = 0; k < 3; k++)
            sum += w[k] * longint'((corner_rgb[k] >> shift) & 8'hFF);
        sum = sum >>> WEIGHT_FRAC_BITS;
        return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    function automatic pixel_t shade_pixel(logic [11:0] qx, logic [11:0] qy);
        pixel_t p;
        longint w[3];
        longint den[3];
        longint px;
        longint py;
        bit cov;
        px = longint'(qx) <<< COORD_FRAC_BITS;
        py = longint'(qy) <<< COORD_FRAC_BITS;
        den[0] = edge_val(1, 2, corner_px[0], corner_py[0]);
        den[1] = edge_val(2, 0, corner_px[1], corner_py[1]);
        den[2] = edge_val(0, 1, corner_px[2], corner_py[2]);
        w = '{0, 0, 0};
        cov = den[0] != 0 && den[1] != 0 && den[2] != 0 && qx < width_reg && qy < height_reg;
        if (cov) cov = weight_ok(edge_val(1, 2, px, py), den[0], w[0]);
        if (cov) cov = weight_ok(edge_val(2, 0, px, py), den[1], w[1]);
        if (cov) cov = weight_ok(edge_val(0, 1, px, py), den[2], w[2]);
        p.col = qx;
        p.row = qy;
        p.cov = cov;
        p.red = cov ? blend(w, 16) : 8'd0;
        p.green = cov ? blend(w, 8) : 8'd0;
        p.blue = cov ? blend(w, 0) : 8'd0;
        return p;
    endfunction

    task automatic send_item(logic op, logic [1:0] slot, logic [15:0] vx, logic [15:0] vy,
                             logic [23:0] rgb, logic [11:0] qx, logic [11:0] qy);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        vertex_slot <= slot;
        vertex_x <= vx;
        vertex_y <= vy;
        {vertex_red, vertex_green, vertex_blue} <= rgb;
        query_x <= qx;
        query_y <= qy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_QUERY)
            expected_pixels.push_back(shade_pixel(qx, qy));
        else if (slot != SLOT_NONE)
        begin
            corner_px[slot] = longint'($signed(vx));
            corner_py[slot] = longint'($signed(vy));
            corner_rgb[slot] = rgb;
        end
    endtask

    task automatic load_corner(int slot, int x, int y, logic [23:0] rgb);
        send_item(OP_LOAD, slot[1:0], x[15:0], y[15:0], rgb, $urandom, $urandom);
    endtask

    task automatic query_pixel(int qx, int qy);
        send_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, qx[11:0], qy[11:0]);
    endtask

    task automatic write_screen(logic [12:0] w, logic [12:0] h);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        for (int r = 0; r < 2; r++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= (r == 0) ? REG_SCREEN_WIDTH : REG_SCREEN_HEIGHT;
            cfg_data <= (r == 0) ? w : h;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (r == 0) width_reg = w; else height_reg = h;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        out_stall <= !quiet && $urandom_range(0, 99) < 8;

    always @(posedge clk)
    begin
        pixel_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel transfer with nothing expected: col %0d row %0d",
                       pixel_col, pixel_row);
                errors++;
            end
            else
            begin
                e = expected_pixels.pop_front();
                if (pixel_col !== e.col)
                begin
                    $error("pixel_col expected %0d actual %0d", e.col, pixel_col);
                    errors++;
                end
                if (pixel_row !== e.row)
                begin
                    $error("pixel_row expected %0d actual %0d", e.row, pixel_row);
                    errors++;
                end
                if (covered !== e.cov)
                begin
                    $error("covered expected %0d actual %0d", e.cov, covered);
                    errors++;
                end
                if (shade_red !== e.red)
                begin
                    $error("shade_red expected %0d actual %0d", e.red, shade_red);
                    errors++;
                end
                if (shade_green !== e.green)
                begin
                    $error("shade_green expected %0d actual %0d", e.green, shade_green);
                    errors++;
                end
                if (shade_blue !== e.blue)
                begin
                    $error("shade_blue expected %0d actual %0d", e.blue, shade_blue);
                    errors++;
                end
            end
        end
    end

    task automatic test_reset_state();
        query_pixel(0, 0);
        query_pixel(4095, 4095);
    endtask

    task automatic test_directed_triangle();
        load_corner(0, 0, 0, 24'hFF0000);
        load_corner(1, 100 * 16, 0, 24'h00FF00);
        load_corner(2, 0, 100 * 16, 24'h0000FF);
        query_pixel(0, 0);
        query_pixel(100, 0);
        query_pixel(0, 100);
        query_pixel(33, 33);
        query_pixel(50, 50);
        query_pixel(51, 50);
        load_corner(3, -32768, 32767, 24'hFFFFFF);
        query_pixel(10, 10);
        load_corner(0, 1, 3, 24'hFFFFFF);
        query_pixel(0, 0);
        load_corner(0, -32768, -32768, 24'hFFFFFF);
        load_corner(1, 32767, -32768, 24'hFFFFFF);
        load_corner(2, 0, 32767, 24'hFFFFFF);
        query_pixel(1000, 1000);
        query_pixel(4095, 0);
        load_corner(2, 32767, -32768, 24'h808080);
        query_pixel(5, 5);
    endtask

    task automatic test_screen_limits();
        write_screen(13'd0, 13'd0);
        load_corner(0, 0, 0, 24'h123456);
        load_corner(1, 4095 * 16, 0, 24'hABCDEF);
        load_corner(2, 0, 2047 * 16, 24'hFFFFFF);
        query_pixel(0, 0);
        write_screen(13'd1, 13'd1);
        query_pixel(0, 0);
        query_pixel(1, 0);
        write_screen(13'd4096, 13'd4096);
        query_pixel(4000, 10);
        write_screen(13'd8191, 13'd8191);
        query_pixel(2000, 1000);
    endtask

    task automatic test_random_triangles(int n_items);
        int sent;
        int ox;
        int oy;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
                write_screen($urandom_range(1, 4096), $urandom_range(1, 4096));
            quiet = (sent >= 400 && sent < 650) || ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                ox = $urandom_range(0, 3800);
                oy = $urandom_range(0, 3800);
                for (int k = 0; k < 3; k++)
                    load_corner(k, (ox + $urandom_range(0, 250)) * 16 + $urandom_range(0, 15)
                                - 64, (oy + $urandom_range(0, 250)) * 16
                                + $urandom_range(0, 15) - 64, $urandom);
                sent += 3;
                repeat ($urandom_range(3, 10))
                begin
                    query_pixel(ox + $urandom_range(0, 255), oy + $urandom_range(0, 255));
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    send_item($urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
                    sent++;
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        corner_px = '{0, 0, 0};
        corner_py = '{0, 0, 0};
        corner_rgb = '{24'd0, 24'd0, 24'd0};
        width_reg = 13'd640;
        height_reg = 13'd480;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_directed_triangle();
        test_screen_limits();
        test_random_triangles(1100);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- barycentric_triangle_pixel_shader_top.f -----
src/bts_pkg.sv
src/bts_front.sv
src/bts_back.sv
src/barycentric_triangle_pixel_shader_top.sv
dv/barycentric_triangle_pixel_shader_top_test.sv
